FILE: rtl/dcp_pkg.sv
// Package for the distance constraint projection pipeline: payload types and constants.
`timescale 1ns / 1ps
package dcp_pkg;

    localparam int POS_W  = 32;
    localparam int MASS_W = 24;
    localparam int REST_W = 31;
    localparam int DIFF_W = 33;
    localparam int SQ_W   = 66;
    localparam int ROOT_W = 33;
    localparam int WSUM_W = 25;
    localparam int DEN_W  = ROOT_W + WSUM_W;
    localparam int ERR_W  = 33;
    localparam int NUM_W  = DIFF_W + ERR_W + MASS_W;
    localparam int QUO_W  = 35;
    localparam logic [QUO_W-1:0] CAP = QUO_W'(64'd1 << 34);

    typedef struct packed {
        logic signed [POS_W-1:0] a_x;
        logic signed [POS_W-1:0] a_y;
        logic signed [POS_W-1:0] b_x;
        logic signed [POS_W-1:0] b_y;
        logic [MASS_W-1:0]       inv_mass_a;
        logic [MASS_W-1:0]       inv_mass_b;
        logic [REST_W-1:0]       rest_len;
        logic                    masses_alive;
    } joint_t;

    typedef struct packed {
        logic signed [POS_W-1:0] new_a_x;
        logic signed [POS_W-1:0] new_a_y;
        logic signed [POS_W-1:0] new_b_x;
        logic signed [POS_W-1:0] new_b_y;
        logic                    applied;
    } result_t;

endpackage

FILE: rtl/distance_constraint_projection.sv
// Top level of the distance constraint projection pipeline.
// Pipeline stages from start to done: 3 input stages, sqrt 33, 4 setup/multiply, divider 90+1, output.
// Throughput: one joint per cycle; busy is always low.
// Reset clears all valid bits and the sqrt root registers; other payload registers are not reset.
// The receiver cannot stall: each result is shown for one cycle with done high.
`timescale 1ns / 1ps
module distance_constraint_projection
    import dcp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  joint_t  joint,
    output logic    done,
    output result_t result
);

    localparam int LAT = 3 + ROOT_W + 4 + NUM_W + 1 + 1;

    assign busy = 1'b0;

    // stage 1: differences and magnitudes
    logic [DIFF_W-1:0] udx_reg, udy_reg;
    logic              ndx_reg, ndy_reg;
    joint_t            j1_reg;
    always_ff @(posedge clk)
    begin
        logic signed [DIFF_W-1:0] dx, dy;
        dx = DIFF_W'(joint.b_x) - DIFF_W'(joint.a_x);
        dy = DIFF_W'(joint.b_y) - DIFF_W'(joint.a_y);
        udx_reg <= dx[DIFF_W-1] ? -dx : dx;
        udy_reg <= dy[DIFF_W-1] ? -dy : dy;
        ndx_reg <= dx[DIFF_W-1];
        ndy_reg <= dy[DIFF_W-1];
        j1_reg  <= joint;
    end

    // stage 2: squares
    logic [SQ_W-2:0] sx_reg, sy_reg;
    always_ff @(posedge clk)
    begin
        sx_reg <= (SQ_W-1)'(udx_reg) * (SQ_W-1)'(udx_reg);
        sy_reg <= (SQ_W-1)'(udy_reg) * (SQ_W-1)'(udy_reg);
    end

    // stage 3: sum
    logic [SQ_W-1:0] sq_reg;
    always_ff @(posedge clk)
    begin
        sq_reg <= {1'b0, sx_reg} + {1'b0, sy_reg};
    end

    logic [ROOT_W-1:0] d;
    dcp_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .radicand(sq_reg), .root(d));

    // delay line carries sideband past sqrt
    localparam int DL1 = 2 + ROOT_W;
    typedef struct packed {
        joint_t            j;
        logic [DIFF_W-1:0] udx;
        logic [DIFF_W-1:0] udy;
        logic              ndx;
        logic              ndy;
    } side_t;
    side_t side1_reg [DL1];
    always_ff @(posedge clk)
    begin
        side1_reg[0] <= '{j1_reg, udx_reg, udy_reg, ndx_reg, ndy_reg};
        for (int i = 1; i < DL1; i++)
            side1_reg[i] <= side1_reg[i-1];
    end
    side_t s1;
    assign s1 = side1_reg[DL1-1];

    // error, denominator, skip, signs
    logic [ERR_W-1:0] ue_reg;
    logic [DEN_W-1:0] den_reg;
    logic             skip_reg, sgx_reg, sgy_reg;
    side_t            s2_reg;
    always_ff @(posedge clk)
    begin
        logic signed [ERR_W:0] e;
        logic [WSUM_W-1:0]     ws;
        ws = WSUM_W'(s1.j.inv_mass_a) + WSUM_W'(s1.j.inv_mass_b);
        e  = (ERR_W+1)'(d) - (ERR_W+1)'(s1.j.rest_len);
        ue_reg   <= ERR_W'(e[ERR_W] ? -e : e);
        den_reg  <= ((d == '0) || (ws == '0)) ? DEN_W'(1) : DEN_W'(d) * DEN_W'(ws);
        skip_reg <= !s1.j.masses_alive || (ws == '0) || (d == '0);
        sgx_reg  <= s1.ndx != e[ERR_W];
        sgy_reg  <= s1.ndy != e[ERR_W];
        s2_reg   <= s1;
    end

    // products |dc|*|e| then times mass; keep each multiplier around 33x33
    logic [DIFF_W+ERR_W-1:0] px_reg, py_reg;
    logic [DEN_W-1:0]        den2_reg;
    logic                    skip2_reg, sgx2_reg, sgy2_reg;
    side_t                   s3_reg;
    always_ff @(posedge clk)
    begin
        px_reg    <= (DIFF_W+ERR_W)'(s2_reg.udx) * (DIFF_W+ERR_W)'(ue_reg);
        py_reg    <= (DIFF_W+ERR_W)'(s2_reg.udy) * (DIFF_W+ERR_W)'(ue_reg);
        den2_reg  <= den_reg;
        skip2_reg <= skip_reg;
        sgx2_reg  <= sgx_reg;
        sgy2_reg  <= sgy_reg;
        s3_reg    <= s2_reg;
    end

    // split each product into low and high halves before the mass multiply
    localparam int PLO_W = 32;
    localparam int PHI_W = DIFF_W + ERR_W - PLO_W;
    logic [PLO_W+MASS_W-1:0] lax_reg, lay_reg, lbx_reg, lby_reg;
    logic [PHI_W+MASS_W-1:0] hax_reg, hay_reg, hbx_reg, hby_reg;
    logic [DEN_W-1:0]        den3_reg;
    always_ff @(posedge clk)
    begin
        lax_reg  <= (PLO_W+MASS_W)'(px_reg[PLO_W-1:0]) * (PLO_W+MASS_W)'(s3_reg.j.inv_mass_a);
        lay_reg  <= (PLO_W+MASS_W)'(py_reg[PLO_W-1:0]) * (PLO_W+MASS_W)'(s3_reg.j.inv_mass_a);
        lbx_reg  <= (PLO_W+MASS_W)'(px_reg[PLO_W-1:0]) * (PLO_W+MASS_W)'(s3_reg.j.inv_mass_b);
        lby_reg  <= (PLO_W+MASS_W)'(py_reg[PLO_W-1:0]) * (PLO_W+MASS_W)'(s3_reg.j.inv_mass_b);
        hax_reg  <= (PHI_W+MASS_W)'(px_reg[DIFF_W+ERR_W-1:PLO_W]) *
                    (PHI_W+MASS_W)'(s3_reg.j.inv_mass_a);
        hay_reg  <= (PHI_W+MASS_W)'(py_reg[DIFF_W+ERR_W-1:PLO_W]) *
                    (PHI_W+MASS_W)'(s3_reg.j.inv_mass_a);
        hbx_reg  <= (PHI_W+MASS_W)'(px_reg[DIFF_W+ERR_W-1:PLO_W]) *
                    (PHI_W+MASS_W)'(s3_reg.j.inv_mass_b);
        hby_reg  <= (PHI_W+MASS_W)'(py_reg[DIFF_W+ERR_W-1:PLO_W]) *
                    (PHI_W+MASS_W)'(s3_reg.j.inv_mass_b);
        den3_reg <= den2_reg;
    end

    logic [NUM_W-1:0] nax_reg, nay_reg, nbx_reg, nby_reg;
    logic [DEN_W-1:0] den4_reg;
    always_ff @(posedge clk)
    begin
        nax_reg  <= {hax_reg, PLO_W'(0)} + NUM_W'(lax_reg);
        nay_reg  <= {hay_reg, PLO_W'(0)} + NUM_W'(lay_reg);
        nbx_reg  <= {hbx_reg, PLO_W'(0)} + NUM_W'(lbx_reg);
        nby_reg  <= {hby_reg, PLO_W'(0)} + NUM_W'(lby_reg);
        den4_reg <= den3_reg;
    end

    logic [QUO_W-1:0] max_q, may_q, mbx_q, mby_q;
    dcp_div u_div_ax (.clk(clk), .num(nax_reg), .den(den4_reg), .quo(max_q));
    dcp_div u_div_ay (.clk(clk), .num(nay_reg), .den(den4_reg), .quo(may_q));
    dcp_div u_div_bx (.clk(clk), .num(nbx_reg), .den(den4_reg), .quo(mbx_q));
    dcp_div u_div_by (.clk(clk), .num(nby_reg), .den(den4_reg), .quo(mby_q));

    // align sideband to divider output
    localparam int DL2 = 2 + NUM_W + 1;
    typedef struct packed {
        joint_t j;
        logic   skip;
        logic   sgx;
        logic   sgy;
    } tail_t;
    tail_t tail_reg [DL2];
    always_ff @(posedge clk)
    begin
        tail_reg[0] <= '{s3_reg.j, skip2_reg, sgx2_reg, sgy2_reg};
        for (int i = 1; i < DL2; i++)
            tail_reg[i] <= tail_reg[i-1];
    end
    tail_t t;
    assign t = tail_reg[DL2-1];

    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0] p, input logic [QUO_W-1:0] m, input logic neg);
        logic signed [QUO_W+1:0] v;
        v = (QUO_W+2)'(p) + (neg ? -$signed({2'b00, m}) : $signed({2'b00, m}));
        if (v > (QUO_W+2)'(32'sh7fffffff))
            return 32'sh7fffffff;
        else if (v < -(QUO_W+2)'(64'sh80000000))
            return 32'sh80000000;
        else
            return v[POS_W-1:0];
    endfunction

    logic [LAT-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start};
    end
    assign done = vld_reg[LAT-1];

    always_ff @(posedge clk)
    begin
        if (t.skip)
            result <= '{t.j.a_x, t.j.a_y, t.j.b_x, t.j.b_y, 1'b0};
        else
            result <= '{sat_add(t.j.a_x, max_q, t.sgx), sat_add(t.j.a_y, may_q, t.sgy),
                        sat_add(t.j.b_x, mbx_q, !t.sgx), sat_add(t.j.b_y, mby_q, !t.sgy),
                        1'b1};
    end

endmodule

FILE: rtl/dcp_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module dcp_sqrt
    import dcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SQ_W-1:0]   radicand,
    output logic [ROOT_W-1:0] root
);

    logic [SQ_W-1:0]     val_reg  [ROOT_W+1];
    logic [ROOT_W+1:0]   rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]   root_reg [ROOT_W+1];

    always_comb
    begin
        val_reg[0]  = radicand;
        rem_reg[0]  = '0;
        root_reg[0] = '0;
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic [ROOT_W+1:0] rem_next;
        logic [ROOT_W+1:0] trial;
        logic [ROOT_W+1:0] sum;
        always_comb
        begin
            sum      = {rem_reg[k][ROOT_W-1:0], val_reg[k][SQ_W-1 -: 2]};
            trial    = {root_reg[k], 2'b01};
            rem_next = (sum >= trial) ? sum - trial : sum;
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                root_reg[k+1] <= '0;
            end
            else
            begin
                root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], sum >= trial};
            end
        end
        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= rem_next;
            val_reg[k+1] <= {val_reg[k][SQ_W-3:0], 2'b00};
        end
    end

    assign root = root_reg[ROOT_W];

endmodule

FILE: rtl/dcp_div.sv
// Pipelined restoring divider with round-to-nearest and a saturating cap.
`timescale 1ns / 1ps
module dcp_div
    import dcp_pkg::*;
(
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    localparam int R_W = DEN_W + 1;

    logic [NUM_W-1:0] n_reg [NUM_W+1];
    logic [DEN_W-1:0] d_reg [NUM_W+1];
    logic [R_W-1:0]   r_reg [NUM_W+1];
    logic [QUO_W-1:0] q_reg [NUM_W+1];
    logic             s_reg [NUM_W+1];

    always_comb
    begin
        n_reg[0] = num;
        d_reg[0] = den;
        r_reg[0] = '0;
        q_reg[0] = '0;
        s_reg[0] = 1'b0;
    end

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_stage
        logic [R_W:0]     sh;
        logic             ge;
        logic [QUO_W:0]   qn;
        always_comb
        begin
            sh = {r_reg[i], n_reg[i][NUM_W-1]};
            ge = sh >= {2'b00, d_reg[i]};
            qn = {q_reg[i], ge};
        end
        always_ff @(posedge clk)
        begin
            n_reg[i+1] <= {n_reg[i][NUM_W-2:0], 1'b0};
            d_reg[i+1] <= d_reg[i];
            r_reg[i+1] <= ge ? R_W'(sh - {2'b00, d_reg[i]}) : R_W'(sh);
            if (qn > {1'b0, CAP})
            begin
                q_reg[i+1] <= CAP;
                s_reg[i+1] <= 1'b1;
            end
            else
            begin
                q_reg[i+1] <= qn[QUO_W-1:0];
                s_reg[i+1] <= s_reg[i];
            end
        end
    end

    // round half up unless capped
    always_ff @(posedge clk)
    begin
        if (!s_reg[NUM_W] && ({r_reg[NUM_W], 1'b0} >= {2'b00, d_reg[NUM_W]}))
            quo <= q_reg[NUM_W] + 1'b1;
        else
            quo <= q_reg[NUM_W];
    end

endmodule

FILE: tb/dcp_checker.sv
// Checker for the distance constraint projection: predicts each joint result and compares.
`timescale 1ns / 1ps
module dcp_checker
    import dcp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  joint_t  joint,
    input  logic    done,
    input  result_t result,
    output int      fail_count,
    output int      pending
);

    result_t expected_q[$];

    function automatic logic signed [POS_W-1:0] clamp32(input logic signed [71:0] v);
        if (v > 72'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -72'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // round-to-nearest of num/den, capped at CAP (no rounding once capped)
    function automatic logic [QUO_W-1:0] scaled_move(input logic [DIFF_W-1:0] dc,
            input logic [ERR_W-1:0] e, input logic [MASS_W-1:0] m,
            input logic [DEN_W-1:0] den);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        num = 128'(dc) * 128'(e) * 128'(m);
        q = num / 128'(den);
        r = num % 128'(den);
        if (q > 128'(CAP))
            return CAP;
        if (2 * r >= 128'(den))
            q = q + 1;
        return q[QUO_W-1:0];
    endfunction

    function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [SQ_W-1:0] v);
        logic [ROOT_W-1:0] root;
        logic [SQ_W+1:0] trial;
        root = '0;
        for (int k = ROOT_W-1; k >= 0; k--)
        begin
            trial = (SQ_W+2)'(root | (ROOT_W'(1) << k));
            if (trial * trial <= (SQ_W+2)'(v))
                root = root | (ROOT_W'(1) << k);
        end
        return root;
    endfunction

    function automatic result_t project_joint(input joint_t j);
        result_t res;
        logic signed [DIFF_W-1:0] dx, dy;
        logic [DIFF_W-1:0] udx, udy;
        logic [WSUM_W-1:0] wsum;
        logic [ROOT_W-1:0] d;
        logic signed [ERR_W+1:0] e;
        logic [ERR_W-1:0] ue;
        logic [DEN_W-1:0] den;
        logic signed [71:0] mx_a, my_a, mx_b, my_b;
        res.new_a_x = j.a_x;
        res.new_a_y = j.a_y;
        res.new_b_x = j.b_x;
        res.new_b_y = j.b_y;
        res.applied = 1'b0;
        dx = DIFF_W'(j.b_x) - DIFF_W'(j.a_x);
        dy = DIFF_W'(j.b_y) - DIFF_W'(j.a_y);
        udx = dx < 0 ? -dx : dx;
        udy = dy < 0 ? -dy : dy;
        wsum = WSUM_W'(j.inv_mass_a) + WSUM_W'(j.inv_mass_b);
        if (!j.masses_alive || wsum == 0 || (udx == 0 && udy == 0))
            return res;
        d = floor_sqrt(SQ_W'(udx) * SQ_W'(udx) + SQ_W'(udy) * SQ_W'(udy));
        den = DEN_W'(d) * DEN_W'(wsum);
        e = $signed({2'b0, d}) - $signed({4'b0, j.rest_len});
        ue = ERR_W'(e < 0 ? -e : e);
        mx_a = 72'(scaled_move(udx, ue, j.inv_mass_a, den));
        my_a = 72'(scaled_move(udy, ue, j.inv_mass_a, den));
        mx_b = 72'(scaled_move(udx, ue, j.inv_mass_b, den));
        my_b = 72'(scaled_move(udy, ue, j.inv_mass_b, den));
        // flip the move when delta and length error disagree in sign
        if ((dx < 0) != (e < 0))
        begin
            mx_a = -mx_a;
            mx_b = -mx_b;
        end
        if ((dy < 0) != (e < 0))
        begin
            my_a = -my_a;
            my_b = -my_b;
        end
        res.new_a_x = clamp32(72'(j.a_x) + mx_a);
        res.new_a_y = clamp32(72'(j.a_y) + my_a);
        res.new_b_x = clamp32(72'(j.b_x) - mx_b);
        res.new_b_y = clamp32(72'(j.b_y) - my_b);
        res.applied = 1'b1;
        return res;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_q.delete();
        end
        else
        begin
            if (start && !busy)
                expected_q.push_back(project_joint(joint));
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result transaction %h", result);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want !== result)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: ax %h/%h ay %h/%h bx %h/%h by %h/%h app %b/%b",
                                want.new_a_x, result.new_a_x, want.new_a_y, result.new_a_y,
                                want.new_b_x, result.new_b_x, want.new_b_y, result.new_b_y,
                                want.applied, result.applied);
                    end
                end
            end
        end
    end

endmodule

FILE: tb/testbench.sv
// Top of the distance constraint projection testbench: stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import dcp_pkg::*;

    localparam int DRAIN_CYCLES = 200;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    joint_t  joint;
    logic    done;
    result_t result;
    int      fail_count;
    int      pending;

    distance_constraint_projection uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .joint(joint), .done(done), .result(result)
    );

    dcp_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .joint(joint),
        .done(done), .result(result), .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7fffffff - $urandom_range(0, 3);
            2: return 32'h80000000 + $urandom_range(0, 3);
            default: return $signed(32'($urandom_range(0, 32'h000fffff))) - 32'sh00080000;
        endcase
    endfunction

    function automatic joint_t random_joint();
        joint_t j;
        j.a_x = pick_pos();
        j.a_y = pick_pos();
        // keep B mostly near A so the correction stays in range
        if ($urandom_range(0, 3) != 0)
        begin
            j.b_x = j.a_x + $signed(32'($urandom_range(0, 32'h0003ffff))) - 32'sh00020000;
            j.b_y = j.a_y + $signed(32'($urandom_range(0, 32'h0003ffff))) - 32'sh00020000;
        end
        else
        begin
            j.b_x = pick_pos();
            j.b_y = pick_pos();
        end
        case ($urandom_range(0, 3))
            0: j.inv_mass_a = 24'($urandom());
            1: j.inv_mass_a = '0;
            default: j.inv_mass_a = 24'($urandom_range(0, 24'h02ffff));
        endcase
        case ($urandom_range(0, 3))
            0: j.inv_mass_b = 24'($urandom());
            1: j.inv_mass_b = '0;
            default: j.inv_mass_b = 24'($urandom_range(0, 24'h02ffff));
        endcase
        j.rest_len = $urandom_range(0, 7) == 0 ? 31'($urandom()) :
                     31'($urandom_range(0, 32'h00030000));
        j.masses_alive = $urandom_range(0, 7) != 0;
        return j;
    endfunction

    // leave start high after the accepting edge; drop it only for an idle gap
    task automatic send_joint(input joint_t j);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        joint <= j;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_both(input logic [31:0] ax, input logic [31:0] ay,
            input logic [31:0] bx, input logic [31:0] by, input logic [23:0] ma,
            input logic [23:0] mb, input logic [30:0] rest, input logic alive);
        joint_t j;
        j = '{ax, ay, bx, by, ma, mb, rest, alive};
        send_joint(j);
    endtask

    initial
    begin
        int waited;
        start = 1'b0;
        joint = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: skips, zero move, extremes, saturation
        send_both(0, 0, 32'h10000, 0, 24'h10000, 24'h10000, 31'h8000, 1'b0);
        send_both(5, 7, 5, 7, 24'h10000, 24'h10000, 31'h10000, 1'b1);
        send_both(0, 0, 32'h10000, 0, 0, 0, 31'h8000, 1'b1);
        send_both(0, 0, 32'h30000, 32'h40000, 24'h10000, 24'h10000, 31'h50000, 1'b1);
        send_both(0, 0, 32'h10000, 0, 24'h10000, 24'h10000, 31'h8000, 1'b1);
        send_both(0, 0, 32'h10000, 32'h10000, 24'h10000, 0, 31'h40000, 1'b1);
        send_both(0, 0, 1, 0, 24'hffffff, 24'hffffff, 31'h7fffffff, 1'b1);
        send_both(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                  24'hffffff, 24'h000001, 31'h0, 1'b1);
        send_both(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                  24'h000001, 24'hffffff, 31'h7fffffff, 1'b1);
        send_both(32'h7fffffff, 0, 32'h7ffffff0, 0, 24'hffffff, 24'hffffff, 31'h7fffffff, 1'b1);
        send_both(32'hfffffff0, 32'h00000010, 32'h00000010, 32'hfffffff0,
                  24'h000001, 24'h000001, 31'h5, 1'b1);
        send_both(32'h12345678, 32'h87654321, 32'hedcba987, 32'h789abcde,
                  24'hffffff, 24'hffffff, 31'h7fffffff, 1'b1);
        send_both(0, 0, 3, 4, 24'h10000, 24'h10000, 31'h5, 1'b1);
        send_both(0, 0, 0, 32'hffff0000, 24'h8000, 24'h18000, 31'h20000, 1'b1);
        start <= 1'b0;
        // hold off until every result has come back
        waited = 0;
        while (pending != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        for (int n = 0; n < 500; n++)
            send_joint(random_joint());
        start <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
